@@ src/dsu_pkg.sv @@
// Shared types and constants for the descriptive statistics unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package dsu_pkg;

    localparam int SAMPLE_W = 28;
    localparam int OUT_W    = 32;
    localparam int VAR_W    = 31;
    localparam int TOTAL_W  = 11;
    localparam int ZQ       = 16;

    localparam logic [7:0]  DIV_STEPS_FULL = 8'd128;
    localparam logic [7:0]  Z_DIV_STEPS    = 8'd48;
    localparam logic [6:0]  MUL_STEPS      = 7'd64;
    localparam logic [5:0]  SQRT_STEPS     = 6'd32;

    localparam logic [30:0] VAR_MAX      = 31'h7FFF_FFFF;
    localparam logic [23:0] Z_MAX        = 24'hFF_FFFF;
    localparam logic [63:0] SKEW_POS_CAP = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SKEW_NEG_CAP = 64'h0000_0000_8000_0000;
    localparam logic [63:0] T1_CAP       = 64'h0000_0100_0000_0000;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_LAST   = 2'd1,
        MODE_REPEAT = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0]                 mode;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] minimum;
        logic signed [OUT_W-1:0] maximum;
        logic signed [OUT_W-1:0] mean;
        logic [VAR_W-1:0]        variance;
        logic [VAR_W-1:0]        std_dev;
        logic [VAR_W-1:0]        std_error;
        logic signed [OUT_W-1:0] skewness;
        logic signed [OUT_W-1:0] kurtosis;
        logic [TOTAL_W-1:0]      sample_total;
        logic                    overflowed;
    } t_result;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MEAN,
        ST_P1,
        ST_VAR,
        ST_SD,
        ST_SEDIV,
        ST_SE,
        ST_P2_RD,
        ST_P2_DAT,
        ST_P2_DIV,
        ST_P2_Z2,
        ST_P2_Z3,
        ST_P2_Z4,
        ST_SK_DEN,
        ST_SK_MUL,
        ST_SK_DIV,
        ST_KU_A,
        ST_KU_NUM,
        ST_KU_B,
        ST_KU_C,
        ST_KU_DIV,
        ST_KU_E,
        ST_KU_F,
        ST_KU_CORR,
        ST_FINISH,
        ST_EMIT
    } t_state;

endpackage
`default_nettype wire

@@ src/dsu_front.sv @@
// Input side: accepts items, drops unused mode codes, queues the rest (2 deep).
// Depends on dsu_pkg.
`default_nettype none
module dsu_front import dsu_pkg::*; (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_mode,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_q_valid,
    output t_item                           o_q_item,
    input  wire logic                       i_q_pop
);

    t_item      r_entry [2];
    logic       r_wp, r_rp, n_wp, n_rp;
    logic [1:0] r_fill, n_fill;
    logic       keep, push, pop;

    assign o_ready   = (r_fill != 2'd2);
    assign keep      = (i_mode == MODE_SAMPLE) || (i_mode == MODE_LAST) ||
                       (i_mode == MODE_REPEAT);
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_item  = r_entry[r_rp];
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wp   = push ? ~r_wp : r_wp;
        n_rp   = pop ? ~r_rp : r_rp;
        n_fill = r_fill + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wp].mode   <= i_mode;
            r_entry[r_wp].sample <= i_sample;
        end
    end

endmodule
`default_nettype wire

@@ src/dsu_div.sv @@
// Restoring divider, one quotient bit per cycle, 128-bit dividend, 64-bit divisor.
// Depends on dsu_pkg.
`default_nettype none
module dsu_div import dsu_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [127:0] i_num,
    input  wire logic [63:0]  i_den,
    input  wire logic [7:0]   i_steps,
    output logic              o_done,
    output logic [127:0]      o_quot
);

    logic         r_busy, n_busy, r_done, n_done;
    logic [7:0]   r_cnt, n_cnt;
    logic [127:0] r_q;
    logic [63:0]  r_rem, r_den;
    logic [64:0]  rem2, diff;
    logic         ge;

    assign rem2   = {r_rem, r_q[127]};
    assign diff   = rem2 - {1'b0, r_den};
    assign ge     = (rem2 >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_q;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_steps;
        end else if (r_busy) begin
            n_cnt = r_cnt - 8'd1;
            if (r_cnt == 8'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 8'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num << (DIV_STEPS_FULL - i_steps);
            r_rem <= 64'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[126:0], ge};
            r_rem <= ge ? diff[63:0] : rem2[63:0];
        end
    end

endmodule
`default_nettype wire

@@ src/dsu_sqrt.sv @@
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on dsu_pkg.
`default_nettype none
module dsu_sqrt import dsu_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_v,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy, n_busy, r_done, n_done;
    logic [5:0]  r_cnt, n_cnt;
    logic [63:0] r_v, r_r, r_b, trial;
    logic        ge;

    assign trial  = r_r + r_b;
    assign ge     = (r_v >= trial);
    assign o_done = r_done;
    assign o_root = r_r[31:0];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = SQRT_STEPS;
        end else if (r_busy) begin
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_v;
            r_r <= 64'd0;
            r_b <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (ge) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

endmodule
`default_nettype wire

@@ src/dsu_mul.sv @@
// Shift-add multiplier, 64 x 64 to 128 bits, one multiplier bit per cycle.
// Depends on dsu_pkg.
`default_nettype none
module dsu_mul import dsu_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [63:0]  i_a,
    input  wire logic [63:0]  i_b,
    output logic              o_done,
    output logic [127:0]      o_prod
);

    logic         r_busy, n_busy, r_done, n_done;
    logic [6:0]   r_cnt, n_cnt;
    logic [63:0]  r_a, r_b;
    logic [127:0] r_p;
    logic [64:0]  psum;

    assign psum   = {1'b0, r_p[127:64]} + (r_b[0] ? {1'b0, r_a} : 65'd0);
    assign o_done = r_done;
    assign o_prod = r_p;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = MUL_STEPS;
        end else if (r_busy) begin
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_p <= 128'd0;
        end else if (r_busy) begin
            r_p <= {psum, r_p[63:1]};
            r_b <= r_b >> 1;
        end
    end

endmodule
`default_nettype wire

@@ src/dsu_back.sv @@
// Execution side: sample store, running min/max/sum, end-of-list statistics sequencer
// and the output register. Depends on dsu_pkg, dsu_div, dsu_sqrt, dsu_mul.
`default_nettype none
module dsu_back import dsu_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  wire t_item i_q_item,
    output logic       o_q_pop,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_result    o_result
);

    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int AW  = $clog2(MAX_SAMPLES);
    localparam int SW  = SAMPLE_W + CW;
    localparam int S2W = 2 * (SAMPLE_W + 1) + CW;

    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] r_rdata;

    t_state r_state, n_state;
    logic   r_issued, n_issued;
    logic [CW-1:0] r_count, n_count, r_idx, n_idx;
    logic signed [SAMPLE_W-1:0] r_min, n_min, r_max, n_max;
    logic signed [SW-1:0] r_sum, n_sum;
    logic r_drop, n_drop;
    logic signed [SAMPLE_W:0] r_mean, n_mean;
    logic [S2W-1:0] r_s2, n_s2;
    logic [57:0] r_sq, n_sq;
    logic r_rv1, n_rv1, r_rv2, n_rv2;
    logic [30:0] r_var, n_var;
    logic [31:0] r_sd, n_sd, r_se, n_se;
    logic [63:0] r_tmp, n_tmp, r_sum3, n_sum3, r_sum4, n_sum4, r_t1, n_t1;
    logic [SAMPLE_W:0] r_ad, n_ad;
    logic r_neg, n_neg;
    logic [23:0] r_z, n_z;
    logic [31:0] r_z2, n_z2;
    logic [127:0] r_num, n_num;
    logic [31:0] r_skew, n_skew, r_kurt, n_kurt;
    t_result r_stored, n_stored, r_out, n_out;
    logic r_out_valid, n_out_valid;

    logic take, wr_en, rd_en, out_free;
    logic [AW-1:0] rd_addr;
    logic signed [SAMPLE_W-1:0] x_in, x_rd;
    logic signed [SAMPLE_W+1:0] d_rd;
    logic [SAMPLE_W:0] ad_rd;
    logic [57:0] sq_p;
    logic [SW-1:0] sum_mag;
    logic [63:0] m3, e3, skew_cap, skew_q, t1_sat;
    logic [30:0] var_q, var_sat;
    logic [23:0] z_sat;
    logic [47:0] zz;
    logic [55:0] z3p;
    logic [63:0] z4p;
    logic [39:0] z3;
    logic [31:0] skew_v, kurt_sat, cnt32;
    logic signed [65:0] kdiff;

    logic div_start, div_done, mul_start, mul_done, sqrt_start, sqrt_done;
    logic [127:0] div_num, div_q, mul_p;
    logic [63:0] div_den, mul_a, mul_b, sqrt_v;
    logic [7:0] div_steps;
    logic [31:0] sqrt_r;

    dsu_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_num(div_num),
        .i_den(div_den), .i_steps(div_steps), .o_done(div_done), .o_quot(div_q)
    );

    dsu_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(sqrt_start), .i_v(sqrt_v),
        .o_done(sqrt_done), .o_root(sqrt_r)
    );

    dsu_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(mul_start), .i_a(mul_a),
        .i_b(mul_b), .o_done(mul_done), .o_prod(mul_p)
    );

    assign x_in     = i_q_item.sample;
    assign x_rd     = $signed(r_rdata);
    assign d_rd     = (SAMPLE_W+2)'(x_rd) - (SAMPLE_W+2)'(r_mean);
    assign ad_rd    = d_rd[SAMPLE_W+1] ? (SAMPLE_W+1)'(-d_rd) : (SAMPLE_W+1)'(d_rd);
    assign sq_p     = ad_rd * ad_rd;
    assign sum_mag  = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign m3       = r_sum3[63] ? -r_sum3 : r_sum3;
    assign e3       = ((mul_p[63:0] << 1) + mul_p[63:0]) << FRAC_BITS;
    assign var_q    = (div_q > 128'(VAR_MAX)) ? VAR_MAX : div_q[30:0];
    assign var_sat  = (var_q == 31'd0) ? 31'd1 : var_q;
    assign z_sat    = (div_q > 128'(Z_MAX)) ? Z_MAX : div_q[23:0];
    assign zz       = r_z * r_z;
    assign z3p      = r_z2 * r_z;
    assign z4p      = r_z2 * r_z2;
    assign z3       = 40'(z3p >> ZQ);
    assign skew_cap = r_sum3[63] ? SKEW_NEG_CAP : SKEW_POS_CAP;
    assign skew_q   = (div_q > 128'(skew_cap)) ? skew_cap : div_q[63:0];
    assign skew_v   = r_sum3[63] ? 32'(-skew_q) : 32'(skew_q);
    assign t1_sat   = (div_q > 128'(T1_CAP)) ? T1_CAP : div_q[63:0];
    assign kdiff    = $signed({2'b00, r_t1}) - $signed({2'b00, div_q[63:0]});
    assign kurt_sat = (kdiff > 66'sh0_7FFF_FFFF) ? 32'h7FFF_FFFF :
                      (kdiff < -66'sh0_8000_0000) ? 32'h8000_0000 : kdiff[31:0];
    assign cnt32    = 32'(r_count);
    assign out_free = !r_out_valid || i_ready;
    assign rd_addr  = r_idx[AW-1:0];
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_state = r_state;   n_issued = r_issued; n_count = r_count; n_idx = r_idx;
        n_min = r_min;       n_max = r_max;       n_sum = r_sum;     n_drop = r_drop;
        n_mean = r_mean;     n_s2 = r_s2;         n_sq = r_sq;       n_rv1 = r_rv1;
        n_rv2 = r_rv2;       n_var = r_var;       n_sd = r_sd;       n_se = r_se;
        n_tmp = r_tmp;       n_sum3 = r_sum3;     n_sum4 = r_sum4;   n_t1 = r_t1;
        n_ad = r_ad;         n_neg = r_neg;       n_z = r_z;         n_z2 = r_z2;
        n_num = r_num;       n_skew = r_skew;     n_kurt = r_kurt;   n_stored = r_stored;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_ready;
        o_q_pop = 1'b0; take = 1'b0; wr_en = 1'b0; rd_en = 1'b0;
        div_start = 1'b0; div_num = '0; div_den = '0; div_steps = DIV_STEPS_FULL;
        mul_start = 1'b0; mul_a = '0; mul_b = '0;
        sqrt_start = 1'b0; sqrt_v = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.mode)
                        MODE_SAMPLE: begin
                            take = 1'b1;
                            o_q_pop = 1'b1;
                        end
                        MODE_LAST: begin
                            take = 1'b1;
                            o_q_pop = 1'b1;
                            n_issued = 1'b0;
                            n_state = ST_MEAN;
                        end
                        MODE_REPEAT: begin
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                n_out_valid = 1'b1;
                                n_out = r_stored;
                            end
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            ST_MEAN: begin
                div_num = 128'(sum_mag) + 128'(r_count >> 1);
                div_den = 64'(r_count);
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued = 1'b1;
                end else if (div_done) begin
                    n_issued = 1'b0;
                    n_mean = r_sum[SW-1] ? -$signed({1'b0, div_q[SAMPLE_W-1:0]})
                                         : $signed({1'b0, div_q[SAMPLE_W-1:0]});
                    n_var = '0; n_sd = '0; n_se = '0; n_skew = '0; n_kurt = '0;
                    n_idx = '0; n_s2 = '0; n_rv1 = 1'b0; n_rv2 = 1'b0;
                    n_state = (r_count >= CW'(2)) ? ST_P1 : ST_FINISH;
                end
            end
            ST_P1: begin
                if (r_idx != r_count) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + CW'(1);
                end
                n_rv1 = (r_idx != r_count);
                n_rv2 = r_rv1;
                if (r_rv1) n_sq = sq_p;
                if (r_rv2) n_s2 = r_s2 + S2W'(r_sq);
                if (r_idx == r_count && !r_rv1 && !r_rv2) n_state = ST_VAR;
            end
            ST_VAR: begin
                div_num = 128'(r_s2);
                div_den = 64'(r_count - CW'(1)) << FRAC_BITS;
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued = 1'b1;
                end else if (div_done) begin
                    n_issued = 1'b0;
                    n_var = var_sat;
                    n_state = ST_SD;
                end
            end
            ST_SD: begin
                sqrt_v = 64'(r_var) << FRAC_BITS;
                if (!r_issued) begin
                    sqrt_start = 1'b1;
                    n_issued = 1'b1;
                end else if (sqrt_done) begin
                    n_issued = 1'b0;
                    n_sd = sqrt_r;
                    n_state = ST_SEDIV;
                end
            end
            ST_SEDIV: begin
                div_num = 128'(64'(r_var) << FRAC_BITS);
                div_den = 64'(r_count);
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued = 1'b1;
                end else if (div_done) begin
                    n_issued = 1'b0;
                    n_tmp = div_q[63:0];
                    n_state = ST_SE;
                end
            end
            ST_SE: begin
                sqrt_v = r_tmp;
                if (!r_issued) begin
                    sqrt_start = 1'b1;
                    n_issued = 1'b1;
                end else if (sqrt_done) begin
                    n_issued = 1'b0;
                    n_se = sqrt_r;
                    n_idx = '0; n_sum3 = '0; n_sum4 = '0;
                    n_state = (r_count >= CW'(3)) ? ST_P2_RD : ST_FINISH;
                end
            end
            ST_P2_RD: begin
                rd_en = 1'b1;
                n_state = ST_P2_DAT;
            end
            ST_P2_DAT: begin
                n_ad = ad_rd;
                n_neg = d_rd[SAMPLE_W+1];
                n_state = ST_P2_DIV;
            end
            ST_P2_DIV: begin
                div_num = 128'(r_ad) << ZQ;
                div_den = 64'(r_sd);
                div_steps = Z_DIV_STEPS;
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued = 1'b1;
                end else if (div_done) begin
                    n_issued = 1'b0;
                    n_z = z_sat;
                    n_state = ST_P2_Z2;
                end
            end
            ST_P2_Z2: begin
                n_z2 = 32'(zz >> ZQ);
                n_state = ST_P2_Z3;
            end
            ST_P2_Z3: begin
                n_sum3 = r_neg ? r_sum3 - 64'(z3) : r_sum3 + 64'(z3);
                n_state = ST_P2_Z4;
            end
            ST_P2_Z4: begin
                n_sum4 = r_sum4 + (z4p >> ZQ);
                n_idx = r_idx + CW'(1);
                n_state = (r_idx == r_count - CW'(1)) ? ST_SK_DEN : ST_P2_RD;
            end
            ST_SK_DEN: begin
                mul_a = 64'(r_count) - 64'd1;
                mul_b = 64'(r_count) - 64'd2;
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_tmp = mul_p[63:0];
                    n_state = ST_SK_MUL;
                end
            end
            ST_SK_MUL: begin
                mul_a = m3;
                mul_b = 64'(r_count);
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_num = mul_p << FRAC_BITS;
                    n_state = ST_SK_DIV;
                end
            end
            ST_SK_DIV: begin
                div_num = r_num;
                div_den = r_tmp << ZQ;
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued = 1'b1;
                end else if (div_done) begin
                    n_issued = 1'b0;
                    n_skew = skew_v;
                    n_state = (r_count >= CW'(4)) ? ST_KU_A : ST_FINISH;
                end
            end
            ST_KU_A: begin
                mul_a = 64'(r_count);
                mul_b = 64'(r_count) + 64'd1;
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_tmp = mul_p[63:0];
                    n_state = ST_KU_NUM;
                end
            end
            ST_KU_NUM: begin
                mul_a = r_sum4;
                mul_b = r_tmp;
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_num = mul_p << FRAC_BITS;
                    n_state = ST_KU_B;
                end
            end
            ST_KU_B: begin
                mul_a = 64'(r_count) - 64'd1;
                mul_b = 64'(r_count) - 64'd2;
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_tmp = mul_p[63:0];
                    n_state = ST_KU_C;
                end
            end
            ST_KU_C: begin
                mul_a = r_tmp;
                mul_b = 64'(r_count) - 64'd3;
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_tmp = mul_p[63:0];
                    n_state = ST_KU_DIV;
                end
            end
            ST_KU_DIV: begin
                div_num = r_num;
                div_den = r_tmp << ZQ;
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued = 1'b1;
                end else if (div_done) begin
                    n_issued = 1'b0;
                    n_t1 = t1_sat;
                    n_state = ST_KU_E;
                end
            end
            ST_KU_E: begin
                mul_a = 64'(r_count) - 64'd1;
                mul_b = 64'(r_count) - 64'd1;
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_num = 128'(e3);
                    n_state = ST_KU_F;
                end
            end
            ST_KU_F: begin
                mul_a = 64'(r_count) - 64'd2;
                mul_b = 64'(r_count) - 64'd3;
                if (!r_issued) begin
                    mul_start = 1'b1;
                    n_issued = 1'b1;
                end else if (mul_done) begin
                    n_issued = 1'b0;
                    n_tmp = mul_p[63:0];
                    n_state = ST_KU_CORR;
                end
            end
            ST_KU_CORR: begin
                div_num = r_num;
                div_den = r_tmp;
                if (!r_issued) begin
                    div_start = 1'b1;
                    n_issued = 1'b1;
                end else if (div_done) begin
                    n_issued = 1'b0;
                    n_kurt = kurt_sat;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_stored.minimum      = OUT_W'(r_min);
                n_stored.maximum      = OUT_W'(r_max);
                n_stored.mean         = OUT_W'(r_mean);
                n_stored.variance     = r_var;
                n_stored.std_dev      = r_sd[31] ? VAR_MAX : r_sd[30:0];
                n_stored.std_error    = r_se[31] ? VAR_MAX : r_se[30:0];
                n_stored.skewness     = $signed(r_skew);
                n_stored.kurtosis     = $signed(r_kurt);
                n_stored.sample_total = cnt32[TOTAL_W-1:0];
                n_stored.overflowed   = r_drop;
                n_count = '0; n_min = '0; n_max = '0; n_sum = '0; n_drop = 1'b0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = r_stored;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (take) begin
            if (r_count >= CW'(MAX_SAMPLES)) begin
                n_drop = 1'b1;
            end else begin
                wr_en = 1'b1;
                if (r_count == '0 || x_in < r_min) n_min = x_in;
                if (r_count == '0 || x_in > r_max) n_max = x_in;
                n_sum = r_sum + SW'(x_in);
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_count     <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_drop      <= 1'b0;
            r_rv1       <= 1'b0;
            r_rv2       <= 1'b0;
            r_stored    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_sum       <= n_sum;
            r_drop      <= n_drop;
            r_rv1       <= n_rv1;
            r_rv2       <= n_rv2;
            r_stored    <= n_stored;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_mean <= n_mean;
        r_s2   <= n_s2;
        r_sq   <= n_sq;
        r_var  <= n_var;
        r_sd   <= n_sd;
        r_se   <= n_se;
        r_tmp  <= n_tmp;
        r_sum3 <= n_sum3;
        r_sum4 <= n_sum4;
        r_t1   <= n_t1;
        r_ad   <= n_ad;
        r_neg  <= n_neg;
        r_z    <= n_z;
        r_z2   <= n_z2;
        r_num  <= n_num;
        r_skew <= n_skew;
        r_kurt <= n_kurt;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_count[AW-1:0]] <= x_in;
        if (rd_en) r_rdata <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ src/descriptive_statistics_unit.sv @@
// Top level of the descriptive statistics unit: input queue and execution side.
// Depends on dsu_pkg, dsu_front, dsu_back.
//
// Usage: items arrive on the input valid/ready channel with a mode and a signed
// Q11.16 sample. Mode sample stores the sample; mode last stores it and closes
// the list; mode repeat re-sends the last result; the unused code is swallowed.
// Results leave on the output valid/ready channel, one per last or repeat item.
// Throughput: one sample item per cycle while no list is being closed. Closing a list
// runs on the serial divider, the serial multiplier and the serial square root;
// the first pass reads the sample memory one entry a cycle.
// No items are taken while a list is being closed beyond the 2-entry queue.
// A repeat item yields its result once the block is idle and the output register is free.
// Reset clears counts, running min/max/sum, the kept result (all zeros) and the
// queue. When the receiver stalls, the result stays in the output register and
// the block holds further results until it is taken.
`default_nettype none
module descriptive_statistics_unit import dsu_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_mode,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic signed [OUT_W-1:0]         o_minimum,
    output logic signed [OUT_W-1:0]         o_maximum,
    output logic signed [OUT_W-1:0]         o_mean,
    output logic [VAR_W-1:0]                o_variance,
    output logic [VAR_W-1:0]                o_std_dev,
    output logic [VAR_W-1:0]                o_std_error,
    output logic signed [OUT_W-1:0]         o_skewness,
    output logic signed [OUT_W-1:0]         o_kurtosis,
    output logic [TOTAL_W-1:0]              o_sample_total,
    output logic                            o_overflowed
);

    logic    q_valid, q_pop;
    t_item   q_item;
    t_result result;

    dsu_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_mode(i_mode), .i_sample(i_sample), .o_q_valid(q_valid),
        .o_q_item(q_item), .i_q_pop(q_pop)
    );

    dsu_back #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .i_q_item(q_item),
        .o_q_pop(q_pop), .o_valid(o_valid), .i_ready(i_ready), .o_result(result)
    );

    assign o_minimum      = result.minimum;
    assign o_maximum      = result.maximum;
    assign o_mean         = result.mean;
    assign o_variance     = result.variance;
    assign o_std_dev      = result.std_dev;
    assign o_std_error    = result.std_error;
    assign o_skewness     = result.skewness;
    assign o_kurtosis     = result.kurtosis;
    assign o_sample_total = result.sample_total;
    assign o_overflowed   = result.overflowed;

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for descriptive_statistics_unit: table-driven directed lists, a list
// that overruns the sample store, then random lists, all checked against a predictor.
// Depends on dsu_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
    import dsu_pkg::*;

    localparam int STORE_DEPTH  = 1024;
    localparam int FRAC         = 16;
    localparam int IDLE_LIMIT   = 400000;
    localparam int RANDOM_ITEMS = 1900;

    typedef struct {
        t_mode           mode;
        logic [27:0]     sample;
        bit              pin;
        int              pin_min;
        int              pin_max;
        int              pin_mean;
        int              pin_total;
    } t_row;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_ready;
    logic [1:0]                i_mode;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                      o_valid;
    logic                      i_ready;
    logic signed [OUT_W-1:0]   o_minimum;
    logic signed [OUT_W-1:0]   o_maximum;
    logic signed [OUT_W-1:0]   o_mean;
    logic [VAR_W-1:0]          o_variance;
    logic [VAR_W-1:0]          o_std_dev;
    logic [VAR_W-1:0]          o_std_error;
    logic signed [OUT_W-1:0]   o_skewness;
    logic signed [OUT_W-1:0]   o_kurtosis;
    logic [TOTAL_W-1:0]        o_sample_total;
    logic                      o_overflowed;

    descriptive_statistics_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_mode(i_mode), .i_sample(i_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_minimum(o_minimum), .o_maximum(o_maximum), .o_mean(o_mean),
        .o_variance(o_variance), .o_std_dev(o_std_dev), .o_std_error(o_std_error),
        .o_skewness(o_skewness), .o_kurtosis(o_kurtosis),
        .o_sample_total(o_sample_total), .o_overflowed(o_overflowed)
    );

    // predictor state
    logic signed [27:0] list_store [STORE_DEPTH];
    int unsigned        list_count;
    longint             list_min, list_max, list_sum;
    bit                 list_dropped;
    t_result            kept_stats;

    t_result stats_due [$];
    int      errors;
    int      items_sent;
    int      stats_seen;
    int      idle_cycles;
    bit      burst;
    int      ready_bias;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned div_capped(logic [127:0] num, longint unsigned d,
                                                   longint unsigned cap);
        logic [127:0] q;
        if (d == 0) return cap;
        q = num / {64'h0, d};
        if (q > {64'h0, cap}) return cap;
        return q[63:0];
    endfunction

    function automatic t_result close_list();
        t_result         r;
        longint unsigned n, mag, var_q, sd, se, m3, q, sum4, t1, corr, z, z2, z3, ad;
        longint          mean, dlt, sum3, skew, kurt;
        logic [127:0]    s2, num;
        n = list_count;
        var_q = 0; sd = 0; se = 0; skew = 0; kurt = 0; sum3 = 0; sum4 = 0; s2 = 0;
        mag = list_sum < 0 ? longint'(-list_sum) : longint'(list_sum);
        mag = (mag + n / 2) / n;
        mean = list_sum < 0 ? -longint'(mag) : longint'(mag);
        if (n >= 2) begin
            for (int i = 0; i < list_count; i++) begin
                dlt = longint'(list_store[i]) - mean;
                ad = dlt < 0 ? -dlt : dlt;
                s2 += {64'h0, ad * ad};
            end
            var_q = div_capped(s2, (n - 1) << FRAC, 64'h7FFF_FFFF);
            if (var_q == 0) var_q = 1;
            sd = isqrt(var_q << FRAC);
            se = isqrt((var_q << FRAC) / n);
        end
        if (n >= 3) begin
            for (int i = 0; i < list_count; i++) begin
                dlt = longint'(list_store[i]) - mean;
                ad = dlt < 0 ? -dlt : dlt;
                z = (ad << 16) / sd;
                if (z > 64'hFF_FFFF) z = 64'hFF_FFFF;
                z2 = (z * z) >> 16;
                z3 = (z2 * z) >> 16;
                sum3 += dlt < 0 ? -longint'(z3) : longint'(z3);
                sum4 += (z2 * z2) >> 16;
            end
            m3 = sum3 < 0 ? -sum3 : sum3;
            num = ({64'h0, m3} * {64'h0, n}) << FRAC;
            q = div_capped(num, ((n - 1) * (n - 2)) << 16,
                           sum3 < 0 ? 64'h8000_0000 : 64'h7FFF_FFFF);
            skew = sum3 < 0 ? -longint'(q) : longint'(q);
        end
        if (n >= 4) begin
            num = ({64'h0, sum4} * {64'h0, n * (n + 1)}) << FRAC;
            t1 = div_capped(num, ((n - 1) * (n - 2) * (n - 3)) << 16, 64'h1 << 40);
            corr = ((3 * (n - 1) * (n - 1)) << FRAC) / ((n - 2) * (n - 3));
            kurt = longint'(t1) - longint'(corr);
            if (kurt > 64'sd2147483647) kurt = 64'sd2147483647;
            if (kurt < -64'sd2147483648) kurt = -64'sd2147483648;
        end
        r.minimum      = 32'(list_min);
        r.maximum      = 32'(list_max);
        r.mean         = 32'(mean);
        r.variance     = 31'(var_q);
        r.std_dev      = sd > 64'h7FFF_FFFF ? VAR_MAX : 31'(sd);
        r.std_error    = se > 64'h7FFF_FFFF ? VAR_MAX : 31'(se);
        r.skewness     = 32'(skew);
        r.kurtosis     = 32'(kurt);
        r.sample_total = 11'(list_count);
        r.overflowed   = list_dropped;
        return r;
    endfunction

    function automatic void store_sample(logic signed [27:0] x);
        if (list_count >= STORE_DEPTH) begin
            list_dropped = 1'b1;
            return;
        end
        list_store[list_count] = x;
        if (list_count == 0 || x < list_min) list_min = x;
        if (list_count == 0 || x > list_max) list_max = x;
        list_sum += x;
        list_count++;
    endfunction

    // returns 1 when the item yields a result
    function automatic bit predict_item(logic [1:0] m, logic signed [27:0] x);
        if (m == MODE_SAMPLE) begin
            store_sample(x);
            return 1'b0;
        end
        if (m == MODE_LAST) begin
            store_sample(x);
            kept_stats   = close_list();
            list_count   = 0;
            list_min     = 0;
            list_max     = 0;
            list_sum     = 0;
            list_dropped = 1'b0;
        end
        if (m == MODE_LAST || m == MODE_REPEAT) begin
            stats_due.push_back(kept_stats);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int pick_gap();
        int p;
        if (burst) return 0;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_item(logic [1:0] m, logic [27:0] s, output bit yields);
        int g;
        g = pick_gap();
        repeat (g) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid  <= 1'b1;
        i_mode   <= m;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        yields = predict_item(m, s);
        items_sent++;
        if ($urandom_range(0, 99) < 3) burst = ~burst;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (stats_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [27:0] draw_value(int style, int center, int spread);
        longint v;
        case (style)
            0: v = $signed(28'($urandom));
            1: v = center + longint'($urandom_range(0, spread)) - spread / 2;
            2: v = center;
            default: v = ($urandom_range(0, 9) == 0) ? center + spread * 50 : center;
        endcase
        if (v > 134217727) v = 134217727;
        if (v < -134217728) v = -134217728;
        return 28'(v);
    endfunction

    task automatic send_list(int len, bit tail_repeat);
        int  style, center, spread;
        bit  y;
        style  = $urandom_range(0, 3);
        center = $signed(28'($urandom)) >>> $urandom_range(0, 27);
        spread = 1 << $urandom_range(0, 20);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 3) send_item(2'd3, 28'($urandom), y);
            send_item(k == len - 1 ? MODE_LAST : MODE_SAMPLE,
                      draw_value(style, center, spread), y);
        end
        if (tail_repeat) send_item(MODE_REPEAT, 28'($urandom), y);
    endtask

    task automatic check_field(string name, longint expv, longint actv);
        if (expv != actv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) ready_bias <= $urandom_range(0, 3);
        case (ready_bias)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 99) < 70;
            2: i_ready <= $urandom_range(0, 99) < 30;
            default: i_ready <= $urandom_range(0, 99) < 5;
        endcase
    end

    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            stats_seen++;
            if (stats_due.size() == 0) begin
                $error("result with none expected");
                errors++;
            end else begin
                e = stats_due.pop_front();
                check_field("minimum", e.minimum, o_minimum);
                check_field("maximum", e.maximum, o_maximum);
                check_field("mean", e.mean, o_mean);
                check_field("variance", e.variance, o_variance);
                check_field("std_dev", e.std_dev, o_std_dev);
                check_field("std_error", e.std_error, o_std_error);
                check_field("skewness", e.skewness, o_skewness);
                check_field("kurtosis", e.kurtosis, o_kurtosis);
                check_field("sample_total", e.sample_total, o_sample_total);
                check_field("overflowed", e.overflowed, o_overflowed);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    t_row plan [] = '{
        '{MODE_REPEAT, 28'h0,       1'b1, 0, 0, 0, 0},
        '{t_mode'(2'd3), 28'h5A5A5A5, 1'b0, 0, 0, 0, 0},
        '{MODE_LAST,   28'h7FF_FFFF, 1'b1, 134217727, 134217727, 134217727, 1},
        '{MODE_LAST,   28'h800_0000, 1'b1, -134217728, -134217728, -134217728, 1},
        '{MODE_REPEAT, 28'hFFF_FFFF, 1'b1, -134217728, -134217728, -134217728, 1},
        '{MODE_SAMPLE, 28'h001_0000, 1'b0, 0, 0, 0, 0},
        '{MODE_LAST,   28'h001_0000, 1'b1, 65536, 65536, 65536, 2},
        '{MODE_SAMPLE, 28'h7FF_FFFF, 1'b0, 0, 0, 0, 0},
        '{MODE_SAMPLE, 28'h800_0000, 1'b0, 0, 0, 0, 0},
        '{MODE_LAST,   28'h000_0000, 1'b1, -134217728, 134217727, 0, 3},
        '{MODE_SAMPLE, 28'hFFF_0000, 1'b0, 0, 0, 0, 0},
        '{MODE_SAMPLE, 28'h002_0000, 1'b0, 0, 0, 0, 0},
        '{t_mode'(2'd3), 28'h7FF_FFFF, 1'b0, 0, 0, 0, 0},
        '{MODE_SAMPLE, 28'h000_8000, 1'b0, 0, 0, 0, 0},
        '{MODE_LAST,   28'h050_0000, 1'b0, 0, 0, 0, 0},
        '{MODE_SAMPLE, 28'h000_0001, 1'b0, 0, 0, 0, 0},
        '{MODE_SAMPLE, 28'h000_0002, 1'b0, 0, 0, 0, 0},
        '{MODE_SAMPLE, 28'h000_0003, 1'b0, 0, 0, 0, 0},
        '{MODE_SAMPLE, 28'h000_0004, 1'b0, 0, 0, 0, 0},
        '{MODE_LAST,   28'h7FF_FFFF, 1'b0, 0, 0, 0, 0},
        '{MODE_REPEAT, 28'h0,       1'b0, 0, 0, 0, 0}
    };

    initial begin
        bit y;
        int remaining;
        t_result last;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_mode     = MODE_SAMPLE;
        i_sample   = '0;
        i_ready    = 1'b0;
        ready_bias = 0;
        burst      = 1'b0;
        errors     = 0;
        items_sent = 0;
        stats_seen = 0;
        idle_cycles = 0;
        list_count = 0; list_min = 0; list_max = 0; list_sum = 0;
        list_dropped = 1'b0;
        kept_stats = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            send_item(plan[r].mode, plan[r].sample, y);
            if (y && plan[r].pin) begin
                last = stats_due[$];
                if (last.minimum != plan[r].pin_min || last.maximum != plan[r].pin_max ||
                    last.mean != plan[r].pin_mean ||
                    last.sample_total != plan[r].pin_total) begin
                    $error("table row %0d: predicted stats disagree with pinned values", r);
                    errors++;
                end
            end
        end
        wait_drained();

        // list that overruns the store; the closing sample is dropped as well
        for (int k = 0; k < STORE_DEPTH + 3; k++)
            send_item(MODE_SAMPLE, 28'($urandom), y);
        send_item(MODE_LAST, 28'($urandom), y);
        send_item(MODE_REPEAT, 28'h0, y);

        remaining = RANDOM_ITEMS - items_sent;
        while (remaining > 0 || stats_seen + stats_due.size() < 60) begin
            int len;
            int start;
            start = items_sent;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            send_list(len, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 19) == 0) begin
                send_item(MODE_REPEAT, 28'($urandom), y);
                send_item(2'd3, 28'($urandom), y);
            end
            remaining -= items_sent - start;
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("covered %0d items and %0d results: single-sample, constant, extreme,",
                 items_sent, stats_seen);
        $display("store-overrun, repeat and unused-mode cases under random stalls");
        if (errors == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end
endmodule

@@ descriptive_statistics_unit.f @@
src/dsu_pkg.sv
src/dsu_front.sv
src/dsu_div.sv
src/dsu_sqrt.sv
src/dsu_mul.sv
src/dsu_back.sv
src/descriptive_statistics_unit.sv
bench/tb_top.sv
